### hdl/wnps_pkg.sv
// shared constants, types and helper functions for the neighbour pixel search
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package wnps_pkg;

    localparam int REACH      = 3;
    localparam int COORD_BITS = 12;
    localparam int PART_BITS  = COORD_BITS + 1;
    localparam int DIFF_BITS  = COORD_BITS + 2;
    localparam int DIST_BITS  = 8;
    localparam int DIR_BITS   = 2;
    localparam int WIN_SIDE   = 2 * REACH + 1;
    localparam int WIN_BITS   = WIN_SIDE * WIN_SIDE;
    localparam int IW         = $clog2(WIN_SIDE);
    localparam int OW         = IW + 1;

    // heading codes; anything else means no heading
    localparam logic [DIR_BITS-1:0] DIR_NORTH = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_WEST  = 2'd1;

    // signed offset or reach, -REACH..REACH
    typedef logic signed [OW-1:0] t_off;

    typedef struct packed {
        t_off n;
        t_off s;
        t_off w;
        t_off e;
    } t_reach;

    // band enables: on +x edge, on +y edge, on -x edge
    typedef struct packed {
        logic px;
        logic py;
        logic mx;
    } t_band_en;

    function automatic t_off clip_reach(input logic signed [DIFF_BITS-1:0] d);
        t_off r;
        if (d < 0) begin
            r = '0;
        end else if (d > $signed(DIFF_BITS'(REACH))) begin
            r = OW'(REACH);
        end else begin
            r = OW'(d);
        end
        return r;
    endfunction

    function automatic t_off idx_to_off(input logic [IW-1:0] idx);
        return $signed({1'b0, idx}) - $signed(OW'(REACH));
    endfunction

    // lowest set bit
    function automatic logic [IW-1:0] first_up(input logic [WIN_SIDE-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int k = WIN_SIDE - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = IW'(k);
            end
        end
        return idx;
    endfunction

    // highest set bit
    function automatic logic [IW-1:0] first_down(input logic [WIN_SIDE-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int k = 0; k < WIN_SIDE; k++) begin
            if (v[k]) begin
                idx = IW'(k);
            end
        end
        return idx;
    endfunction

endpackage

### hdl/wnps_reach.sv
// reach towards each side: partition distance clipped, then heading adjustment
// depends on wnps_pkg
`timescale 1ns / 1ps

module wnps_reach (
    input  logic [wnps_pkg::COORD_BITS-1:0] i_pix_x,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_pix_y,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_part_min_x,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_part_min_y,
    input  logic [wnps_pkg::PART_BITS-1:0]  i_part_max_x,
    input  logic [wnps_pkg::PART_BITS-1:0]  i_part_max_y,
    input  logic [wnps_pkg::DIR_BITS-1:0]   i_direction,
    input  logic [wnps_pkg::DIST_BITS-1:0]  i_distance,
    output wnps_pkg::t_reach                o_reach
);

    logic signed [wnps_pkg::DIFF_BITS-1:0] d_n, d_s, d_w, d_e;
    wnps_pkg::t_off dist_c, base_n, base_s, base_w, base_e;

    always_comb begin
        d_n = $signed({2'b00, i_pix_y}) - $signed({2'b00, i_part_min_y});
        d_s = $signed({1'b0, i_part_max_y}) - $signed(wnps_pkg::DIFF_BITS'(1))
              - $signed({2'b00, i_pix_y});
        d_w = $signed({2'b00, i_pix_x}) - $signed({2'b00, i_part_min_x});
        d_e = $signed({1'b0, i_part_max_x}) - $signed(wnps_pkg::DIFF_BITS'(1))
              - $signed({2'b00, i_pix_x});

        base_n = wnps_pkg::clip_reach(d_n);
        base_s = wnps_pkg::clip_reach(d_s);
        base_w = wnps_pkg::clip_reach(d_w);
        base_e = wnps_pkg::clip_reach(d_e);

        if (i_distance > wnps_pkg::DIST_BITS'(wnps_pkg::REACH)) begin
            dist_c = wnps_pkg::OW'(wnps_pkg::REACH);
        end else begin
            dist_c = wnps_pkg::OW'(i_distance);
        end

        o_reach.n = base_n;
        o_reach.w = base_w;
        o_reach.s = base_s;
        o_reach.e = base_e;
        // a heading with a step sets the opposite reach to step - 1 - the reach ahead, may go negative
        if (dist_c != '0) begin
            if (i_direction == wnps_pkg::DIR_NORTH) begin
                o_reach.s = dist_c - $signed(wnps_pkg::OW'(1)) - base_n;
            end
            if (i_direction == wnps_pkg::DIR_WEST) begin
                o_reach.e = dist_c - $signed(wnps_pkg::OW'(1)) - base_w;
            end
        end
    end

endmodule

### hdl/wnps_scan.sv
// band masking and two-level priority pick over the bitmap window
// depends on wnps_pkg
`timescale 1ns / 1ps

module wnps_scan (
    input  logic [wnps_pkg::WIN_BITS-1:0] i_window,
    input  wnps_pkg::t_reach              i_reach,
    input  wnps_pkg::t_band_en            i_band_en,
    output logic                          o_found,
    output wnps_pkg::t_off                o_dx,
    output wnps_pkg::t_off                o_dy
);

    logic [wnps_pkg::WIN_SIDE-1:0] win_row [wnps_pkg::WIN_SIDE];
    logic [wnps_pkg::WIN_SIDE-1:0] col_a, col_b, col_c;
    logic [wnps_pkg::WIN_SIDE-1:0] hit_a, hit_b, hit_c;
    logic [wnps_pkg::IW-1:0] fc_a [wnps_pkg::WIN_SIDE];
    logic [wnps_pkg::IW-1:0] fc_b [wnps_pkg::WIN_SIDE];
    logic [wnps_pkg::IW-1:0] fc_c [wnps_pkg::WIN_SIDE];
    logic [wnps_pkg::IW-1:0] ra, rb, rc;
    wnps_pkg::t_off off;

    always_comb begin
        // column ranges are the same for every row
        for (int i = 0; i < wnps_pkg::WIN_SIDE; i++) begin
            off      = wnps_pkg::idx_to_off(wnps_pkg::IW'(i));
            col_a[i] = (off > 0) && (off <= i_reach.e);
            col_b[i] = (off >= -i_reach.w) && (off <= i_reach.e);
            col_c[i] = (off >= -i_reach.w) && (off < 0);
        end
        for (int r = 0; r < wnps_pkg::WIN_SIDE; r++) begin
            off        = wnps_pkg::idx_to_off(wnps_pkg::IW'(r));
            win_row[r] = i_window[r*wnps_pkg::WIN_SIDE +: wnps_pkg::WIN_SIDE];
            hit_a[r]   = i_band_en.px && (off >= -i_reach.n) && (off <= i_reach.s)
                         && |(win_row[r] & col_a);
            hit_b[r]   = i_band_en.py && (off > 0) && (off <= i_reach.s)
                         && |(win_row[r] & col_b);
            hit_c[r]   = i_band_en.mx && (off >= -i_reach.n) && (off <= i_reach.s)
                         && |(win_row[r] & col_c);
            // +x band runs right to left, the others left to right
            fc_a[r]    = wnps_pkg::first_down(win_row[r] & col_a);
            fc_b[r]    = wnps_pkg::first_up(win_row[r] & col_b);
            fc_c[r]    = wnps_pkg::first_up(win_row[r] & col_c);
        end
        // +y band runs bottom to top, the others top to bottom
        ra = wnps_pkg::first_up(hit_a);
        rb = wnps_pkg::first_down(hit_b);
        rc = wnps_pkg::first_up(hit_c);

        o_found = 1'b1;
        if (|hit_a) begin
            o_dx = wnps_pkg::idx_to_off(fc_a[ra]);
            o_dy = wnps_pkg::idx_to_off(ra);
        end else if (|hit_b) begin
            o_dx = wnps_pkg::idx_to_off(fc_b[rb]);
            o_dy = wnps_pkg::idx_to_off(rb);
        end else if (|hit_c) begin
            o_dx = wnps_pkg::idx_to_off(fc_c[rc]);
            o_dy = wnps_pkg::idx_to_off(rc);
        end else begin
            o_found = 1'b0;
            o_dx    = '0;
            o_dy    = '0;
        end
    end

endmodule

### hdl/window_neighbor_pixel_search.sv
// top level of the neighbour pixel search: request register, search logic, result register
// depends on wnps_pkg, wnps_reach and wnps_scan
// an accepted request is held in the request register and moves into the result register once that is free
// throughput: one request per cycle while the result channel does not stall
// a held result does not block the request register, so one more request is taken
// reset (synchronous, active low) clears both valid flags; payload registers are not reset
`timescale 1ns / 1ps

module window_neighbor_pixel_search (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [wnps_pkg::WIN_BITS-1:0]   i_window,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_pix_x,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_pix_y,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_part_min_x,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_part_min_y,
    input  logic [wnps_pkg::PART_BITS-1:0]  i_part_max_x,
    input  logic [wnps_pkg::PART_BITS-1:0]  i_part_max_y,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_box_min_x,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_box_max_x,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_box_max_y,
    input  logic [wnps_pkg::DIR_BITS-1:0]   i_direction,
    input  logic [wnps_pkg::DIST_BITS-1:0]  i_distance,
    // result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_found,
    output logic [wnps_pkg::COORD_BITS-1:0] o_result_x,
    output logic [wnps_pkg::COORD_BITS-1:0] o_result_y
);

    // request register
    logic                            r_in_valid, n_in_valid;
    logic [wnps_pkg::WIN_BITS-1:0]   r_window;
    logic [wnps_pkg::COORD_BITS-1:0] r_pix_x, r_pix_y;
    logic [wnps_pkg::COORD_BITS-1:0] r_part_min_x, r_part_min_y;
    logic [wnps_pkg::PART_BITS-1:0]  r_part_max_x, r_part_max_y;
    logic [wnps_pkg::COORD_BITS-1:0] r_box_min_x, r_box_max_x, r_box_max_y;
    logic [wnps_pkg::DIR_BITS-1:0]   r_direction;
    logic [wnps_pkg::DIST_BITS-1:0]  r_distance;

    // result register
    logic                            r_out_valid, n_out_valid;
    logic                            r_found, n_found;
    logic [wnps_pkg::COORD_BITS-1:0] r_res_x, n_res_x;
    logic [wnps_pkg::COORD_BITS-1:0] r_res_y, n_res_y;

    logic                            take_in;   // request accepted this cycle
    logic                            out_free;  // result register can load
    wnps_pkg::t_reach                reach;
    wnps_pkg::t_band_en              band_en;
    logic                            scan_found;
    wnps_pkg::t_off                  scan_dx, scan_dy;

    // handshake: the request register stalls only when it is full and the
    // result register is holding a result that is itself stalled
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = r_in_valid && !out_free;
    assign take_in  = i_valid && !o_stall;

    always_comb begin
        n_in_valid  = o_stall ? r_in_valid : i_valid;
        n_out_valid = out_free ? r_in_valid : r_out_valid;
    end

    // reach to each side after partition clipping and heading adjustment
    wnps_reach u_reach (
        .i_pix_x      (r_pix_x),
        .i_pix_y      (r_pix_y),
        .i_part_min_x (r_part_min_x),
        .i_part_min_y (r_part_min_y),
        .i_part_max_x (r_part_max_x),
        .i_part_max_y (r_part_max_y),
        .i_direction  (r_direction),
        .i_distance   (r_distance),
        .o_reach      (reach)
    );

    // a band is only searched when the pixel sits on that box edge
    always_comb begin
        band_en.px = (r_pix_x == r_box_max_x);
        band_en.py = (r_pix_y == r_box_max_y);
        band_en.mx = (r_pix_x == r_box_min_x);
    end

    wnps_scan u_scan (
        .i_window  (r_window),
        .i_reach   (reach),
        .i_band_en (band_en),
        .o_found   (scan_found),
        .o_dx      (scan_dx),
        .o_dy      (scan_dy)
    );

    // offsets are zero when nothing is found, so the centre pixel comes back;
    // coordinates wrap to the coordinate width
    always_comb begin
        n_found = scan_found;
        n_res_x = r_pix_x + {{(wnps_pkg::COORD_BITS - wnps_pkg::OW){scan_dx[wnps_pkg::OW-1]}},
                             scan_dx};
        n_res_y = r_pix_y + {{(wnps_pkg::COORD_BITS - wnps_pkg::OW){scan_dy[wnps_pkg::OW-1]}},
                             scan_dy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_window     <= i_window;
            r_pix_x      <= i_pix_x;
            r_pix_y      <= i_pix_y;
            r_part_min_x <= i_part_min_x;
            r_part_min_y <= i_part_min_y;
            r_part_max_x <= i_part_max_x;
            r_part_max_y <= i_part_max_y;
            r_box_min_x  <= i_box_min_x;
            r_box_max_x  <= i_box_max_x;
            r_box_max_y  <= i_box_max_y;
            r_direction  <= i_direction;
            r_distance   <= i_distance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_found <= n_found;
            r_res_x <= n_res_x;
            r_res_y <= n_res_y;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_found    = r_found;
    assign o_result_x = r_res_x;
    assign o_result_y = r_res_y;

    // stall is raised only with both registers full and the result held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("request stall without a held result");

    // a pending request moves into the result register when it is free
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_free) |=> o_valid)
        else $error("pending request lost on its way to the result register");

    // an accepted request always lands in the request register
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_in |=> r_in_valid)
        else $error("accepted request not held");

endmodule

### tb/search_result_checker.sv
// result checker for the neighbour pixel search: predicts each request and compares results
// depends on wnps_pkg for widths and heading codes
`timescale 1ns / 1ps

module search_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel, watched only
    input  logic                            i_req_valid,
    input  logic                            i_req_stall,
    input  logic [wnps_pkg::WIN_BITS-1:0]   i_window,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_pix_x,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_pix_y,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_part_min_x,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_part_min_y,
    input  logic [wnps_pkg::PART_BITS-1:0]  i_part_max_x,
    input  logic [wnps_pkg::PART_BITS-1:0]  i_part_max_y,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_box_min_x,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_box_max_x,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_box_max_y,
    input  logic [wnps_pkg::DIR_BITS-1:0]   i_direction,
    input  logic [wnps_pkg::DIST_BITS-1:0]  i_distance,
    // result channel, watched only
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_stall,
    input  logic                            i_found,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_result_x,
    input  logic [wnps_pkg::COORD_BITS-1:0] i_result_y,
    // verdict inputs for the top
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                            found;
        logic [wnps_pkg::COORD_BITS-1:0] x;
        logic [wnps_pkg::COORD_BITS-1:0] y;
    } t_nbr_result;

    t_nbr_result pending_results[$];

    function automatic int clip_span(input int d);
        if (d < 0) begin
            return 0;
        end
        if (d > wnps_pkg::REACH) begin
            return wnps_pkg::REACH;
        end
        return d;
    endfunction

    function automatic bit pixel_set(input logic [wnps_pkg::WIN_BITS-1:0] win,
                                     input int dx, input int dy);
        int idx;
        idx = (dy + wnps_pkg::REACH) * wnps_pkg::WIN_SIDE + dx + wnps_pkg::REACH;
        if (idx < 0 || idx >= wnps_pkg::WIN_BITS) begin
            return 1'b0;
        end
        return win[idx] === 1'b1;
    endfunction

    function automatic t_nbr_result search_neighbour(
        input logic [wnps_pkg::WIN_BITS-1:0]   win,
        input logic [wnps_pkg::COORD_BITS-1:0] pix_x,
        input logic [wnps_pkg::COORD_BITS-1:0] pix_y,
        input logic [wnps_pkg::COORD_BITS-1:0] part_min_x,
        input logic [wnps_pkg::COORD_BITS-1:0] part_min_y,
        input logic [wnps_pkg::PART_BITS-1:0]  part_max_x,
        input logic [wnps_pkg::PART_BITS-1:0]  part_max_y,
        input logic [wnps_pkg::COORD_BITS-1:0] box_min_x,
        input logic [wnps_pkg::COORD_BITS-1:0] box_max_x,
        input logic [wnps_pkg::COORD_BITS-1:0] box_max_y,
        input logic [wnps_pkg::DIR_BITS-1:0]   direction,
        input logic [wnps_pkg::DIST_BITS-1:0]  distance
    );
        int px, py, step, n, s, w, e, x, y, fx, fy;
        bit hit;
        t_nbr_result r;
        px   = pix_x;
        py   = pix_y;
        step = (distance > wnps_pkg::REACH) ? wnps_pkg::REACH : distance;
        n    = clip_span(py - int'(part_min_y));
        s    = clip_span(int'(part_max_y) - 1 - py);
        w    = clip_span(px - int'(part_min_x));
        e    = clip_span(int'(part_max_x) - 1 - px);
        // a heading sets the opposite reach to step - 1 - the reach ahead, possibly below zero
        if (step != 0) begin
            if (direction == wnps_pkg::DIR_NORTH) begin
                s = step - 1 - n;
            end
            if (direction == wnps_pkg::DIR_WEST) begin
                e = step - 1 - w;
            end
        end
        hit = 1'b0;
        fx  = 0;
        fy  = 0;
        if (px == int'(box_max_x)) begin
            for (y = -n; y <= s && !hit; y++) begin
                for (x = e; x > 0 && !hit; x--) begin
                    if (pixel_set(win, x, y)) begin
                        hit = 1'b1;
                        fx  = x;
                        fy  = y;
                    end
                end
            end
        end
        if (!hit && py == int'(box_max_y)) begin
            for (y = s; y > 0 && !hit; y--) begin
                for (x = -w; x <= e && !hit; x++) begin
                    if (pixel_set(win, x, y)) begin
                        hit = 1'b1;
                        fx  = x;
                        fy  = y;
                    end
                end
            end
        end
        if (!hit && px == int'(box_min_x)) begin
            for (y = -n; y <= s && !hit; y++) begin
                for (x = -w; x < 0 && !hit; x++) begin
                    if (pixel_set(win, x, y)) begin
                        hit = 1'b1;
                        fx  = x;
                        fy  = y;
                    end
                end
            end
        end
        r.found = hit;
        r.x     = wnps_pkg::COORD_BITS'(px + fx);
        r.y     = wnps_pkg::COORD_BITS'(py + fy);
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_nbr_result want;
        int fails;
        if (!i_rst_n) begin
            pending_results.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            fails = o_fail_count;
            if (i_rsp_valid && !i_rsp_stall) begin
                if (pending_results.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result found=%0d x=%0d y=%0d",
                                 $time, i_found, i_result_x, i_result_y);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (i_found !== want.found || i_result_x !== want.x ||
                        i_result_y !== want.y) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display({"%0t: result mismatch, expected found=%0d x=%0d y=%0d,",
                                      " got found=%0d x=%0d y=%0d"},
                                     $time, want.found, want.x, want.y,
                                     i_found, i_result_x, i_result_y);
                        end
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                pending_results.push_back(search_neighbour(
                    i_window, i_pix_x, i_pix_y, i_part_min_x, i_part_min_y,
                    i_part_max_x, i_part_max_y, i_box_min_x, i_box_max_x,
                    i_box_max_y, i_direction, i_distance));
            end
            o_fail_count <= fails;
            o_pending    <= pending_results.size();
        end
    end

endmodule

### tb/testbench.sv
// top of the neighbour pixel search testbench: clock, reset, request stimulus and verdict
// depends on wnps_pkg, window_neighbor_pixel_search and search_result_checker
`timescale 1ns / 1ps

module testbench;

    // headings without a meaning of their own in the block
    localparam logic [wnps_pkg::DIR_BITS-1:0] DIR_NONE  = 2'd2;
    localparam logic [wnps_pkg::DIR_BITS-1:0] DIR_SPARE = 2'd3;

    localparam int IDLE_PERCENT   = 21;
    localparam int N_RANDOM       = 1430;
    localparam int HOLD_AT        = 300;   // request index where the long hold-off starts
    localparam int CALM_FROM      = 700;   // stretch with no idling on either side
    localparam int CALM_TO        = 950;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 8;     // settling time after the last result
    localparam int WATCHDOG_LIMIT = 2000;  // well above the hold-off

    // one request, packed so that it is driven by a single assignment
    typedef struct packed {
        logic [wnps_pkg::WIN_BITS-1:0]   window;
        logic [wnps_pkg::COORD_BITS-1:0] pix_x;
        logic [wnps_pkg::COORD_BITS-1:0] pix_y;
        logic [wnps_pkg::COORD_BITS-1:0] part_min_x;
        logic [wnps_pkg::COORD_BITS-1:0] part_min_y;
        logic [wnps_pkg::PART_BITS-1:0]  part_max_x;
        logic [wnps_pkg::PART_BITS-1:0]  part_max_y;
        logic [wnps_pkg::COORD_BITS-1:0] box_min_x;
        logic [wnps_pkg::COORD_BITS-1:0] box_max_x;
        logic [wnps_pkg::COORD_BITS-1:0] box_max_y;
        logic [wnps_pkg::DIR_BITS-1:0]   direction;
        logic [wnps_pkg::DIST_BITS-1:0]  distance;
    } t_query;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_stall;
    t_query                          req       = '0;
    logic                            rsp_valid;
    logic                            rsp_stall = 1'b0;
    logic                            found;
    logic [wnps_pkg::COORD_BITS-1:0] result_x;
    logic [wnps_pkg::COORD_BITS-1:0] result_y;

    // sender-side flags read by the receiver process
    logic                            hold_req  = 1'b0;
    logic                            calm      = 1'b0;

    int                              fail_count;
    int                              pending_count;

    window_neighbor_pixel_search uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (req_valid),
        .o_stall      (req_stall),
        .i_window     (req.window),
        .i_pix_x      (req.pix_x),
        .i_pix_y      (req.pix_y),
        .i_part_min_x (req.part_min_x),
        .i_part_min_y (req.part_min_y),
        .i_part_max_x (req.part_max_x),
        .i_part_max_y (req.part_max_y),
        .i_box_min_x  (req.box_min_x),
        .i_box_max_x  (req.box_max_x),
        .i_box_max_y  (req.box_max_y),
        .i_direction  (req.direction),
        .i_distance   (req.distance),
        .o_valid      (rsp_valid),
        .i_stall      (rsp_stall),
        .o_found      (found),
        .o_result_x   (result_x),
        .o_result_y   (result_y)
    );

    // watches both channels beside the block and keeps the score
    search_result_checker results_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_window     (req.window),
        .i_pix_x      (req.pix_x),
        .i_pix_y      (req.pix_y),
        .i_part_min_x (req.part_min_x),
        .i_part_min_y (req.part_min_y),
        .i_part_max_x (req.part_max_x),
        .i_part_max_y (req.part_max_y),
        .i_box_min_x  (req.box_min_x),
        .i_box_max_x  (req.box_max_x),
        .i_box_max_y  (req.box_max_y),
        .i_direction  (req.direction),
        .i_distance   (req.distance),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_stall  (rsp_stall),
        .i_found      (found),
        .i_result_x   (result_x),
        .i_result_y   (result_y),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin : clock_gen
        forever begin
            #10 clk = ~clk;
        end
    end

    // mask of the window bit at offset (dx, dy) from the centre
    function automatic logic [wnps_pkg::WIN_BITS-1:0] pixel_bit(input int dx, input int dy);
        logic [wnps_pkg::WIN_BITS-1:0] m;
        m = '0;
        m[(dy + wnps_pkg::REACH) * wnps_pkg::WIN_SIDE + dx + wnps_pkg::REACH] = 1'b1;
        return m;
    endfunction

    // centre well inside a partition reaching 2 west and north, 3 east and south;
    // all three box edges pass through the centre, empty window, no heading
    function automatic t_query centred_query(input int px, input int py);
        t_query q;
        q            = '0;
        q.pix_x      = wnps_pkg::COORD_BITS'(px);
        q.pix_y      = wnps_pkg::COORD_BITS'(py);
        q.part_min_x = wnps_pkg::COORD_BITS'(px - 2);
        q.part_min_y = wnps_pkg::COORD_BITS'(py - 2);
        q.part_max_x = wnps_pkg::PART_BITS'(px + 5);
        q.part_max_y = wnps_pkg::PART_BITS'(py + 5);
        q.box_min_x  = wnps_pkg::COORD_BITS'(px);
        q.box_max_x  = wnps_pkg::COORD_BITS'(px);
        q.box_max_y  = wnps_pkg::COORD_BITS'(py);
        q.direction  = DIR_NONE;
        return q;
    endfunction

    // mostly well-formed requests: centre in or just beside a small partition, box edges
    // often on the centre so the bands get scanned; the rest is pure noise
    function automatic t_query random_query();
        t_query q;
        int span_x, span_y, px, py;
        q = '0;
        if ($urandom_range(99) < 12) begin
            q.window     = wnps_pkg::WIN_BITS'({$urandom(), $urandom()});
            q.pix_x      = wnps_pkg::COORD_BITS'($urandom());
            q.pix_y      = wnps_pkg::COORD_BITS'($urandom());
            q.part_min_x = wnps_pkg::COORD_BITS'($urandom());
            q.part_min_y = wnps_pkg::COORD_BITS'($urandom());
            q.part_max_x = wnps_pkg::PART_BITS'($urandom());
            q.part_max_y = wnps_pkg::PART_BITS'($urandom());
            q.box_min_x  = wnps_pkg::COORD_BITS'($urandom());
            q.box_max_x  = wnps_pkg::COORD_BITS'($urandom());
            q.box_max_y  = wnps_pkg::COORD_BITS'($urandom());
            q.direction  = wnps_pkg::DIR_BITS'($urandom());
            q.distance   = wnps_pkg::DIST_BITS'($urandom());
        end else begin
            span_x       = ($urandom_range(3) == 0) ? $urandom_range(1, 300)
                                                    : $urandom_range(1, 8);
            span_y       = ($urandom_range(3) == 0) ? $urandom_range(1, 300)
                                                    : $urandom_range(1, 8);
            q.part_min_x = wnps_pkg::COORD_BITS'($urandom_range(0, 4096 - span_x));
            q.part_min_y = wnps_pkg::COORD_BITS'($urandom_range(0, 4096 - span_y));
            q.part_max_x = wnps_pkg::PART_BITS'(q.part_min_x + span_x);
            q.part_max_y = wnps_pkg::PART_BITS'(q.part_min_y + span_y);
            px = q.part_min_x + $urandom_range(0, span_x - 1);
            py = q.part_min_y + $urandom_range(0, span_y - 1);
            // now and then the centre sits just outside its partition
            if ($urandom_range(9) == 0) begin
                px = $urandom_range(1) ? int'(q.part_min_x) - 1 : int'(q.part_max_x);
            end
            if ($urandom_range(9) == 0) begin
                py = $urandom_range(1) ? int'(q.part_min_y) - 1 : int'(q.part_max_y);
            end
            q.pix_x     = wnps_pkg::COORD_BITS'(px);
            q.pix_y     = wnps_pkg::COORD_BITS'(py);
            q.box_max_x = $urandom_range(1) ? q.pix_x : wnps_pkg::COORD_BITS'($urandom());
            q.box_min_x = $urandom_range(1) ? q.pix_x
                                            : wnps_pkg::COORD_BITS'(px - $urandom_range(1, 5));
            q.box_max_y = $urandom_range(1) ? q.pix_y : wnps_pkg::COORD_BITS'($urandom());
            case ($urandom_range(9))
                0: begin
                    q.window = '0;
                end
                1: begin
                    q.window = '1;
                end
                2, 3, 4: begin
                    q.window = wnps_pkg::WIN_BITS'({$urandom(), $urandom()});
                end
                default: begin
                    // sparse window, so the scan order decides the hit
                    q.window = '0;
                    repeat ($urandom_range(1, 3)) begin
                        q.window[$urandom_range(wnps_pkg::WIN_BITS - 1)] = 1'b1;
                    end
                end
            endcase
            q.direction = wnps_pkg::DIR_BITS'($urandom_range(3));
            q.distance  = ($urandom_range(9) < 7) ? wnps_pkg::DIST_BITS'($urandom_range(4))
                                                  : wnps_pkg::DIST_BITS'($urandom());
        end
        return q;
    endfunction

    // optional idle gap, then offer the request and hold it until the block takes it
    task automatic send_query(input t_query q);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                gap++;
            end
        end
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= q;
        req_valid <= 1'b1;
        do begin
            @(posedge clk);
        end while (req_stall);
    endtask

    // stop offering and wait until every outstanding request has its result;
    // the first edge lets the checker's count take in the last request
    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) begin
            @(posedge clk);
        end
    endtask

    // receiver: random stall, one long hold-off to back the block up, none in the calm stretch
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else if (calm) begin
                rsp_stall <= 1'b0;
            end else begin
                rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // ends the run if neither channel moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        t_query q;
        int k;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty window: nothing to find, centre comes back
        q = centred_query(100, 200);
        send_query(q);
        // full window with all bands on: the +x band wins, top row, far right
        q.window = '1;
        send_query(q);
        // only the +y and -x bands: +y wins from the bottom row
        q.box_max_x = '0;
        send_query(q);
        // only the -x band
        q.box_max_y = '0;
        send_query(q);
        // no band at all
        q.box_min_x = '0;
        send_query(q);

        // heading north, distance one: south reach goes negative
        q           = centred_query(100, 200);
        q.window    = '1;
        q.direction = wnps_pkg::DIR_NORTH;
        q.distance  = 8'd1;
        send_query(q);
        // distance far above the reach is clipped
        q.distance = 8'hFF;
        send_query(q);
        // heading west shortens the east reach
        q.direction = wnps_pkg::DIR_WEST;
        q.distance  = 8'd2;
        send_query(q);
        // spare heading code behaves as no heading
        q.direction = DIR_SPARE;
        send_query(q);
        // heading north with the centre on the partition top row
        q            = centred_query(100, 200);
        q.window     = pixel_bit(1, 2) | pixel_bit(-2, 1);
        q.part_min_y = 12'd200;
        q.direction  = wnps_pkg::DIR_NORTH;
        q.distance   = 8'd3;
        send_query(q);

        // centre outside its partition on both sides: reaches saturate to zero
        q            = centred_query(100, 200);
        q.window     = '1;
        q.part_min_x = 12'd105;
        q.part_max_x = 13'd90;
        send_query(q);
        // one-pixel partition
        q            = centred_query(300, 300);
        q.window     = '1;
        q.part_min_x = 12'd300;
        q.part_min_y = 12'd300;
        q.part_max_x = 13'd301;
        q.part_max_y = 13'd301;
        send_query(q);

        // result column wraps past the top of the coordinate range
        q            = centred_query(4095, 200);
        q.window     = pixel_bit(1, 0);
        q.box_min_x  = '0;
        q.box_max_y  = '0;
        send_query(q);
        // result row wraps
        q            = centred_query(300, 4095);
        q.window     = pixel_bit(0, 3);
        q.part_max_y = '1;
        send_query(q);

        // corner bits only
        q        = centred_query(1000, 1000);
        q.window = pixel_bit(-3, -3) | pixel_bit(3, 3);
        send_query(q);
        // +x hit beats a +y hit further down
        q.window = pixel_bit(1, 2) | pixel_bit(-1, 3);
        send_query(q);

        // all fields at their extremes
        q = '1;
        send_query(q);
        q = '0;
        send_query(q);

        // sender pause until the block is empty
        wait_for_results();

        for (k = 0; k < N_RANDOM; k++) begin
            if (k == HOLD_AT) begin
                hold_req <= 1'b1;
            end
            if (k == CALM_FROM) begin
                calm <= 1'b1;
            end
            if (k == CALM_TO) begin
                calm <= 1'b0;
            end
            send_query(random_query());
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/wnps_pkg.sv
hdl/wnps_reach.sv
hdl/wnps_scan.sv
hdl/window_neighbor_pixel_search.sv
tb/search_result_checker.sv
tb/testbench.sv
